[design/ffa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W     = 16;
    localparam int LEN_W      = 17;
    localparam int END_W      = 18;
    localparam int STAT_W     = 3;

    // bytes in the managed space
    localparam logic [END_W-1:0] MEM_BYTES = END_W'(65536);
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BLOCKS);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_MEM   = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVERLAP  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STAT_W-1:0] ST_ZERO_LEN = 3'd5;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] start_addr;
        logic [LEN_W-1:0]  length;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] block_addr;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } wr_t;

    typedef struct packed {
        logic              fit;
        logic              exact;
        logic              touch;
        logic              overlap;
        logic              after;
        logic              range_bad;
        logic [ADDR_W-1:0] carve_start;
        logic [LEN_W-1:0]  carve_len;
        logic [LEN_W-1:0]  acc_sum;
    } unit_res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FIT,
        S_CARVE,
        S_REMOVE,
        S_MERGE_INIT,
        S_MERGE,
        S_OVL,
        S_INS,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

[design/first_fit_free_list_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// From request transfer to rsp_valid: zero length or range error goes from check to done;
//   allocate scans for the first fit, carves it and removes it on an exact fit, merging
//   the list and scanning again on a first miss; free scans for overlap, then inserts.
// One command at a time through the shared compare/add unit, next request taken the
//   cycle after the result is loaded.
// Reset (rst_n, async low): list holds one block covering all memory, no result pending.
module first_fit_free_list_allocator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ffa_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output ffa_pkg::rsp_t      rsp
);

    ffa_pkg::seq_stat_t stat;
    ffa_pkg::rsp_t      seq_res;
    ffa_pkg::rsp_t      rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               accept;
    logic               out_free;
    logic               load;

    // Requests are only taken while the sequencer is idle; a finished result
    // sitting in the output register does not hold off the next transfer.
    assign req_stall = !stat.idle;
    assign accept    = req_valid && !req_stall;

    // Output register is free when empty or being drained this cycle.
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign load      = stat.done && out_free;

    ffa_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .req      (req),
        .out_free (out_free),
        .stat     (stat),
        .res      (seq_res)
    );

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (load)
        begin
            rsp_next       = seq_res;
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

[design/ffa_store.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffa_store (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [ffa_pkg::IDX_W-1:0] rd_idx,
    output ffa_pkg::entry_t                rd_ent,
    input  wire ffa_pkg::wr_t              wr
);

    ffa_pkg::entry_t entry_reg [ffa_pkg::MAX_BLOCKS];

    // one read port, one write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ffa_pkg::MAX_BLOCKS; i++)
            begin
                entry_reg[i] <= '0;
            end
            entry_reg[0].len <= ffa_pkg::MEM_BYTES[ffa_pkg::LEN_W-1:0];
        end
        else if (wr.en)
        begin
            entry_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_ent = entry_reg[rd_idx];

endmodule
`default_nettype wire

[design/ffa_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffa_unit (
    input  wire ffa_pkg::entry_t ent,
    input  wire ffa_pkg::entry_t acc,
    input  wire ffa_pkg::req_t   req,
    output ffa_pkg::unit_res_t   res
);

    logic [ffa_pkg::END_W-1:0] ent_start;
    logic [ffa_pkg::END_W-1:0] ent_end;
    logic [ffa_pkg::END_W-1:0] acc_end;
    logic [ffa_pkg::END_W-1:0] req_start;
    logic [ffa_pkg::END_W-1:0] req_end;

    always_comb
    begin
        ent_start = ffa_pkg::END_W'(ent.start);
        ent_end   = ent_start + ffa_pkg::END_W'(ent.len);
        acc_end   = ffa_pkg::END_W'(acc.start) + ffa_pkg::END_W'(acc.len);
        req_start = ffa_pkg::END_W'(req.start_addr);
        req_end   = req_start + ffa_pkg::END_W'(req.length);

        res.fit         = (ent.len >= req.length);
        res.exact       = (ent.len == req.length);
        res.touch       = (ent_start == acc_end);
        // half-open interval overlap
        res.overlap     = (req_start < ent_end) && (ent_start < req_end);
        res.after       = (ent.start > req.start_addr);
        res.range_bad   = (req_start >= ffa_pkg::MEM_BYTES) || (req_end > ffa_pkg::MEM_BYTES);
        res.carve_start = ent.start + req.length[ffa_pkg::ADDR_W-1:0];
        res.carve_len   = ent.len - req.length;
        res.acc_sum     = acc.len + ent.len;
    end

endmodule
`default_nettype wire

[design/ffa_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffa_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire ffa_pkg::req_t req,
    input  wire logic          out_free,
    output ffa_pkg::seq_stat_t stat,
    output ffa_pkg::rsp_t      res
);

    localparam int IW = ffa_pkg::IDX_W;
    localparam int CW = ffa_pkg::CNT_W;

    ffa_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [IW-1:0]      wp_reg, wp_next;
    logic [IW-1:0]      hit_reg, hit_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               pos_found_reg, pos_found_next;
    logic               ovl_reg, ovl_next;
    logic               second_reg, second_next;
    logic [CW-1:0]      count_reg, count_next;
    ffa_pkg::entry_t    acc_reg, acc_next;
    ffa_pkg::req_t      cmd_reg, cmd_next;
    ffa_pkg::rsp_t      res_reg, res_next;

    logic [CW-1:0]      ptr_inc;
    logic [CW-1:0]      ptr_dec;
    logic [IW-1:0]      rd_idx;
    ffa_pkg::entry_t    rd_ent;
    ffa_pkg::wr_t       wr;
    ffa_pkg::unit_res_t ur;

    ffa_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (rd_idx),
        .rd_ent (rd_ent),
        .wr     (wr)
    );

    ffa_unit u_unit (
        .ent (rd_ent),
        .acc (acc_reg),
        .req (cmd_reg),
        .res (ur)
    );

    assign ptr_inc = ptr_reg + CW'(1);
    assign ptr_dec = ptr_reg - CW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (start)
                    state_next = ffa_pkg::S_CHECK;
            end
            ffa_pkg::S_CHECK:
            begin
                if (cmd_reg.length == '0)
                    state_next = ffa_pkg::S_DONE;
                else if (cmd_reg.cmd == ffa_pkg::CMD_ALLOC)
                    state_next = ffa_pkg::S_FIT;
                else if (ur.range_bad)
                    state_next = ffa_pkg::S_DONE;
                else
                    state_next = ffa_pkg::S_OVL;
            end
            ffa_pkg::S_FIT:
            begin
                if (ptr_reg < count_reg)
                begin
                    if (ur.fit)
                        state_next = ffa_pkg::S_CARVE;
                end
                else if (second_reg || count_reg == '0)
                    state_next = ffa_pkg::S_DONE;
                else
                    state_next = ffa_pkg::S_MERGE_INIT;
            end
            ffa_pkg::S_CARVE:
            begin
                if (ur.exact)
                    state_next = ffa_pkg::S_REMOVE;
                else
                    state_next = ffa_pkg::S_DONE;
            end
            ffa_pkg::S_REMOVE:
            begin
                if (ptr_inc >= count_reg)
                    state_next = ffa_pkg::S_DONE;
            end
            ffa_pkg::S_MERGE_INIT:
            begin
                state_next = ffa_pkg::S_MERGE;
            end
            ffa_pkg::S_MERGE:
            begin
                if (ptr_reg >= count_reg)
                    state_next = ffa_pkg::S_FIT;
            end
            ffa_pkg::S_OVL:
            begin
                if (ptr_reg >= count_reg)
                begin
                    if (ovl_reg || count_reg >= ffa_pkg::MAX_COUNT)
                        state_next = ffa_pkg::S_DONE;
                    else
                        state_next = ffa_pkg::S_INS;
                end
            end
            ffa_pkg::S_INS:
            begin
                if (ptr_reg <= pos_reg)
                    state_next = ffa_pkg::S_DONE;
            end
            ffa_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = ffa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ffa_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        ptr_next       = ptr_reg;
        wp_next        = wp_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        pos_found_next = pos_found_reg;
        ovl_next       = ovl_reg;
        second_next    = second_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        rd_idx         = ptr_reg[IW-1:0];
        wr             = '0;
        case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (start)
                    cmd_next = req;
            end
            ffa_pkg::S_CHECK:
            begin
                ptr_next       = '0;
                second_next    = 1'b0;
                ovl_next       = 1'b0;
                pos_next       = count_reg;
                pos_found_next = 1'b0;
                res_next.status     = ffa_pkg::ST_OK;
                res_next.block_addr = '0;
                if (cmd_reg.length == '0)
                    res_next.status = ffa_pkg::ST_ZERO_LEN;
                else if (cmd_reg.cmd == ffa_pkg::CMD_FREE && ur.range_bad)
                    res_next.status = ffa_pkg::ST_RANGE;
            end
            ffa_pkg::S_FIT:
            begin
                if (ptr_reg < count_reg)
                begin
                    hit_next = ptr_reg[IW-1:0];
                    ptr_next = ptr_inc;
                end
                else if (second_reg || count_reg == '0)
                    res_next.status = ffa_pkg::ST_NO_MEM;
            end
            ffa_pkg::S_CARVE:
            begin
                rd_idx              = hit_reg;
                res_next.block_addr = rd_ent.start;
                ptr_next            = CW'(hit_reg);
                if (!ur.exact)
                begin
                    wr.en         = 1'b1;
                    wr.idx        = hit_reg;
                    wr.data.start = ur.carve_start;
                    wr.data.len   = ur.carve_len;
                end
            end
            ffa_pkg::S_REMOVE:
            begin
                rd_idx = ptr_inc[IW-1:0];
                if (ptr_inc < count_reg)
                begin
                    wr.en    = 1'b1;
                    wr.idx   = ptr_reg[IW-1:0];
                    wr.data  = rd_ent;
                    ptr_next = ptr_inc;
                end
                else
                    count_next = count_reg - CW'(1);
            end
            ffa_pkg::S_MERGE_INIT:
            begin
                rd_idx   = '0;
                acc_next = rd_ent;
                ptr_next = CW'(1);
                wp_next  = '0;
            end
            ffa_pkg::S_MERGE:
            begin
                if (ptr_reg < count_reg)
                begin
                    ptr_next = ptr_inc;
                    if (ur.touch)
                        acc_next.len = ur.acc_sum;
                    else
                    begin
                        wr.en    = 1'b1;
                        wr.idx   = wp_reg;
                        wr.data  = acc_reg;
                        wp_next  = wp_reg + IW'(1);
                        acc_next = rd_ent;
                    end
                end
                else
                begin
                    // flush the running block, list is now compacted
                    wr.en       = 1'b1;
                    wr.idx      = wp_reg;
                    wr.data     = acc_reg;
                    count_next  = CW'(wp_reg) + CW'(1);
                    ptr_next    = '0;
                    second_next = 1'b1;
                end
            end
            ffa_pkg::S_OVL:
            begin
                if (ptr_reg < count_reg)
                begin
                    ptr_next = ptr_inc;
                    if (ur.overlap)
                        ovl_next = 1'b1;
                    if (!pos_found_reg && ur.after)
                    begin
                        pos_next       = ptr_reg;
                        pos_found_next = 1'b1;
                    end
                end
                else if (ovl_reg)
                    res_next.status = ffa_pkg::ST_OVERLAP;
                else if (count_reg >= ffa_pkg::MAX_COUNT)
                    res_next.status = ffa_pkg::ST_FULL;
                else
                    ptr_next = count_reg;
            end
            ffa_pkg::S_INS:
            begin
                rd_idx = ptr_dec[IW-1:0];
                wr.en  = 1'b1;
                wr.idx = ptr_reg[IW-1:0];
                if (ptr_reg > pos_reg)
                begin
                    wr.data  = rd_ent;
                    ptr_next = ptr_dec;
                end
                else
                begin
                    wr.data.start = cmd_reg.start_addr;
                    wr.data.len   = cmd_reg.length;
                    count_next    = count_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffa_pkg::S_IDLE;
            ptr_reg       <= '0;
            wp_reg        <= '0;
            hit_reg       <= '0;
            pos_reg       <= '0;
            pos_found_reg <= 1'b0;
            ovl_reg       <= 1'b0;
            second_reg    <= 1'b0;
            count_reg     <= CW'(1);
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            wp_reg        <= wp_next;
            hit_reg       <= hit_next;
            pos_reg       <= pos_next;
            pos_found_reg <= pos_found_next;
            ovl_reg       <= ovl_next;
            second_reg    <= second_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    assign stat.idle = (state_reg == ffa_pkg::S_IDLE);
    assign stat.done = (state_reg == ffa_pkg::S_DONE);
    assign res       = res_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ffa_pkg::MAX_COUNT)
        else $error("list count above capacity");

    a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffa_pkg::S_FIT || state_reg == ffa_pkg::S_OVL ||
         state_reg == ffa_pkg::S_MERGE) |-> ptr_reg <= count_reg)
        else $error("scan pointer past list end");

    a_merge_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffa_pkg::S_MERGE) |-> (CW'(wp_reg) < ptr_reg))
        else $error("merge write pointer caught up with read pointer");

    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffa_pkg::S_INS) |->
        (pos_reg <= ptr_reg && ptr_reg <= count_reg && count_reg < ffa_pkg::MAX_COUNT))
        else $error("insert shift out of bounds");

    a_done_leave: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && out_free) |=> stat.idle)
        else $error("result handed over but sequencer not idle");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the first-fit free-list allocator.
//
// A free-list predictor runs alongside the block: each accepted command is
// applied to a local copy of the list and the response it should produce is
// queued.  The response monitor pops that queue on every response transfer
// and compares status and block address.
//
// Stimulus: directed checks of the error codes, the merge-on-miss path and a
// full list, then a receiver hold-off with the sender still pushing, a stretch
// with no idling on either side, and a long random run.  The random run mostly
// allocates and returns blocks the testbench owns, with some noise commands
// (zero length, stray ranges, partial and repeated frees, ranges at the top
// of memory).
module tb_top;

    import ffa_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int END_CYCLES     = 100;   // idle tail after the last response
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either side
    localparam int RANDOM_ITEMS   = 900;
    localparam int STREAM_ITEMS   = 200;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    first_fit_free_list_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Free-list predictor: entries kept in address order, start/length
    // at the block's widths.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] fl_start [MAX_BLOCKS];
    logic [LEN_W-1:0]  fl_len   [MAX_BLOCKS];
    int unsigned       fl_count;

    rsp_t   owed_responses [$];   // responses still to be seen, oldest first
    entry_t held [$];             // blocks the stimulus owns and may return
    entry_t returned [$];         // recently returned ranges, reused for noise

    int mismatches    = 0;
    int items_sent    = 0;
    int allocs_ok     = 0;
    int status_tally [8];
    int longest_hold  = 0;

    bit no_idle      = 1'b0;   // set for the stretch with no idling
    bit hold_request = 1'b0;   // asks the response side for a long hold-off

    function automatic void drop_entry(int unsigned idx);
        for (int unsigned i = idx; i + 1 < fl_count; i++)
        begin
            fl_start[i] = fl_start[i + 1];
            fl_len[i]   = fl_len[i + 1];
        end
        fl_count--;
    endfunction

    function automatic bit first_fit(logic [LEN_W-1:0] want, output int unsigned idx);
        idx = 0;
        for (int unsigned i = 0; i < fl_count; i++)
        begin
            if (fl_len[i] >= want)
            begin
                idx = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one command to the predicted list and returns its response.
    function automatic rsp_t apply_command(req_t item);
        rsp_t             out;
        int unsigned      idx;
        int unsigned      pos;
        int unsigned      m;
        bit               hit;
        bit               clash;
        logic [END_W-1:0] lo;
        logic [END_W-1:0] hi;
        logic [END_W-1:0] ent_end;
        out.status     = ST_OK;
        out.block_addr = '0;
        lo = END_W'(item.start_addr);
        hi = lo + END_W'(item.length);
        if (item.length == '0)
            out.status = ST_ZERO_LEN;
        else if (item.cmd == CMD_ALLOC)
        begin
            hit = first_fit(item.length, idx);
            if (!hit)
            begin
                // miss: fold every touching pair together, then look again
                m = 1;
                while (m < fl_count)
                begin
                    ent_end = END_W'(fl_start[m - 1]) + END_W'(fl_len[m - 1]);
                    if (END_W'(fl_start[m]) == ent_end)
                    begin
                        fl_len[m - 1] = fl_len[m - 1] + fl_len[m];
                        drop_entry(m);
                    end
                    else
                        m++;
                end
                hit = first_fit(item.length, idx);
            end
            if (!hit)
                out.status = ST_NO_MEM;
            else
            begin
                out.block_addr = fl_start[idx];
                if (fl_len[idx] == item.length)
                    drop_entry(idx);
                else
                begin
                    fl_start[idx] = ADDR_W'(fl_start[idx] + item.length);
                    fl_len[idx]   = fl_len[idx] - item.length;
                end
            end
        end
        else if (lo >= MEM_BYTES || hi > MEM_BYTES)
            out.status = ST_RANGE;
        else
        begin
            clash = 1'b0;
            for (int unsigned i = 0; i < fl_count; i++)
            begin
                ent_end = END_W'(fl_start[i]) + END_W'(fl_len[i]);
                if (lo < ent_end && END_W'(fl_start[i]) < hi)
                    clash = 1'b1;
            end
            if (clash)
                out.status = ST_OVERLAP;
            else if (fl_count >= MAX_BLOCKS)
                out.status = ST_FULL;
            else
            begin
                // freed range goes in by address, no merge at this point
                pos = 0;
                while (pos < fl_count && fl_start[pos] <= item.start_addr)
                    pos++;
                for (int unsigned i = fl_count; i > pos; i--)
                begin
                    fl_start[i] = fl_start[i - 1];
                    fl_len[i]   = fl_len[i - 1];
                end
                fl_start[pos] = item.start_addr;
                fl_len[pos]   = item.length;
                fl_count++;
            end
        end
        return out;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one command, waits for its transfer, then predicts the response.
    task automatic send_req(input req_t item, output rsp_t want);
        int unsigned gap;
        if (!no_idle && $urandom_range(99, 0) < 6)
        begin
            // gap of varying length so it lands on any phase of the block's work
            gap = $urandom_range(50, 1);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        want = apply_command(item);
        owed_responses.push_back(want);
        status_tally[want.status]++;
        items_sent++;
        if (item.cmd == CMD_ALLOC && want.status == ST_OK)
            allocs_ok++;
    endtask

    task automatic issue(input logic cmd, input int unsigned start, input int unsigned len);
        req_t item;
        rsp_t want;
        item.cmd        = cmd;
        item.start_addr = ADDR_W'(start);
        item.length     = LEN_W'(len);
        send_req(item, want);
    endtask

    // Sender pause: stop offering and let every owed response arrive.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (owed_responses.size() != 0)
            @(posedge clk);
    endtask

    // Mostly small sizes, a few up to the whole memory.
    function automatic int unsigned pick_size();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 50)
            return $urandom_range(256, 1);
        else if (roll < 85)
            return $urandom_range(4096, 1);
        else if (roll < 97)
            return $urandom_range(32768, 1);
        return $urandom_range(65536, 32768);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_zero_length();
        // zero length wins over every other check, even at the top address of memory
        issue(CMD_ALLOC, 16'hFFFF, 0);
        issue(CMD_FREE, 16'hFFFF, 0);
    endtask

    task automatic test_whole_memory();
        issue(CMD_ALLOC, 16'h0000, 65536);   // takes the lot, list now empty
        issue(CMD_ALLOC, 16'h1234, 1);       // empty list: out of memory
        issue(CMD_FREE, 16'h0000, 65536);    // whole memory back
        issue(CMD_FREE, 16'hFFFF, 2);        // end past memory beats overlap
        issue(CMD_FREE, 16'hFFFF, 1);        // last byte is already free
        issue(CMD_FREE, 16'h8000, 32768);    // upper half overlaps
    endtask

    task automatic test_merge_on_miss();
        issue(CMD_ALLOC, 16'h0000, 100);
        issue(CMD_ALLOC, 16'h0000, 200);
        issue(CMD_FREE, 0, 100);
        issue(CMD_FREE, 100, 200);
        // three touching pieces: only a merge can satisfy a whole-memory request
        issue(CMD_ALLOC, 16'h0000, 65536);
        issue(CMD_FREE, 0, 65536);
    endtask

    task automatic test_list_full();
        issue(CMD_ALLOC, 16'h0000, 32);
        for (int unsigned k = 0; k < MAX_BLOCKS - 1; k++)
            issue(CMD_FREE, 2 * k, 1);        // isolated single bytes fill the list
        issue(CMD_FREE, 30, 1);               // list full
        issue(CMD_FREE, 32, 1);               // overlap is reported before full
        issue(CMD_ALLOC, 16'hABCD, 1);        // exact fit on the first entry
    endtask

    // Receiver holds off while the sender keeps offering, so the block backs up
    // and stalls its input; then the sender waits for everything to drain.
    task automatic test_backpressure();
        req_t item;
        rsp_t want;
        hold_request = 1'b1;
        for (int n = 0; n < 12; n++)
        begin
            item.cmd        = CMD_ALLOC;
            item.start_addr = ADDR_W'($urandom());
            item.length     = LEN_W'($urandom_range(64, 1));
            send_req(item, want);
            if (want.status == ST_OK)
                held.push_back('{start: want.block_addr, len: item.length});
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned count);
        req_t        item;
        rsp_t        want;
        entry_t      pick;
        int unsigned k;
        int unsigned roll;
        int unsigned alloc_pct;
        int unsigned off;
        for (int unsigned n = 0; n < count; n++)
        begin
            item.cmd        = CMD_ALLOC;
            item.start_addr = ADDR_W'($urandom());
            item.length     = LEN_W'(pick_size());
            alloc_pct = (held.size() < 8) ? 60 : ((held.size() > 40) ? 25 : 45);
            roll = $urandom_range(99, 0);
            if (roll < alloc_pct)
            begin
                // reuse a returned size now and then to hit exact fits
                if (returned.size() != 0 && $urandom_range(99, 0) < 15)
                    item.length = returned[$urandom_range(returned.size() - 1, 0)].len;
                send_req(item, want);
                if (want.status == ST_OK)
                    held.push_back('{start: want.block_addr, len: item.length});
            end
            else if (roll < 80 && held.size() != 0)
            begin
                k               = $urandom_range(held.size() - 1, 0);
                pick            = held[k];
                item.cmd        = CMD_FREE;
                item.start_addr = pick.start;
                item.length     = pick.len;
                send_req(item, want);
                if (want.status == ST_OK)
                begin
                    held.delete(k);
                    returned.push_back(pick);
                    if (returned.size() > 32)
                        void'(returned.pop_front());
                end
            end
            else
            begin
                // noise
                item.cmd = CMD_FREE;
                case ($urandom_range(4, 0))
                    0:
                    begin
                        item.cmd    = logic'($urandom_range(1, 0));
                        item.length = '0;
                    end
                    2:
                    begin
                        if (held.size() != 0)
                        begin
                            pick            = held[$urandom_range(held.size() - 1, 0)];
                            off             = $urandom_range(pick.len - 1, 0);
                            item.start_addr = ADDR_W'(pick.start + off);
                            item.length     = LEN_W'($urandom_range(pick.len - off, 1));
                        end
                    end
                    3:
                    begin
                        if (returned.size() != 0)
                        begin
                            pick            = returned[$urandom_range(returned.size() - 1, 0)];
                            item.start_addr = pick.start;
                            item.length     = pick.len;
                        end
                    end
                    4:
                    begin
                        // straddles or just meets the top of memory
                        off             = $urandom_range(4096, 1);
                        item.length     = LEN_W'(off);
                        item.start_addr = ADDR_W'(65536 - off + $urandom_range(3, 0));
                    end
                    default:
                    begin
                    end
                endcase
                send_req(item, want);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: checks each transfer, drives random stalls and the
    // long hold-off, the latter counted here.
    // ------------------------------------------------------------------
    rsp_t want_rsp;
    int   hold_left = 0;

    task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: want status %0d addr 0x%04h, got %0d 0x%04h",
                     $time, what, want.status, want.block_addr, got.status, got.block_addr);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_responses.size() == 0)
                    note_mismatch("unexpected response", '0, rsp);
                else
                begin
                    want_rsp = owed_responses.pop_front();
                    if (rsp.status !== want_rsp.status)
                        note_mismatch("status", want_rsp, rsp);
                    else if (rsp.block_addr !== want_rsp.block_addr)
                        note_mismatch("block_addr", want_rsp, rsp);
                end
            end
            if (hold_left != 0)
            begin
                rsp_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                longest_hold = HOLD_CYCLES;
                rsp_stall   <= 1'b1;
            end
            else if (no_idle)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(99, 0) < 6);
        end
    end

    // Watchdog: any stretch without a transfer on either channel ends the run.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, owed_responses.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        // predictor starts from the reset list: one entry covering memory
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            fl_start[i] = '0;
            fl_len[i]   = '0;
        end
        fl_len[0] = LEN_W'(MEM_BYTES);
        fl_count  = 1;
        foreach (status_tally[i])
            status_tally[i] = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_length();
        test_whole_memory();
        test_merge_on_miss();
        test_list_full();
        test_backpressure();
        no_idle = 1'b1;
        test_random_traffic(STREAM_ITEMS);
        no_idle = 1'b0;
        test_random_traffic(RANDOM_ITEMS);

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        $display("Ran %0d commands: %0d allocations granted, %0d out of memory, %0d frees taken",
                 items_sent, allocs_ok, status_tally[ST_NO_MEM], status_tally[ST_OK] - allocs_ok);
        $display("Rejected: %0d out of range, %0d overlap, %0d full, %0d zero length; hold %0d",
                 status_tally[ST_RANGE], status_tally[ST_OVERLAP], status_tally[ST_FULL],
                 status_tally[ST_ZERO_LEN], longest_hold);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
design/ffa_pkg.sv
design/ffa_store.sv
design/ffa_unit.sv
design/ffa_seq.sv
design/first_fit_free_list_allocator.sv
tb/tb_top.sv
